>>> hw/rtl/dtf_pkg.sv
package dtf_pkg;

    typedef logic [1:0]  t_kind;
    typedef logic [47:0] t_key;
    typedef logic [31:0] t_ident;
    typedef logic [23:0] t_ticks;
    typedef logic [2:0]  t_status;
    typedef logic [4:0]  t_occ;
    typedef logic [4:0]  t_cap;

    localparam t_kind KIND_PUSH = 2'd0;
    localparam t_kind KIND_POP  = 2'd1;
    localparam t_kind KIND_TICK = 2'd2;

    localparam t_status ST_ACCEPTED  = 3'd0;
    localparam t_status ST_DUPLICATE = 3'd1;
    localparam t_status ST_OVERLOAD  = 3'd2;
    localparam t_status ST_EMPTY     = 3'd3;
    localparam t_status ST_POPPED    = 3'd4;
    localparam t_status ST_TIMEOUT   = 3'd5;

    localparam t_cap CAP_RESET = 5'd16;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic scan;       // compare keys and evaluate countdowns
        logic is_tick;    // the scan belongs to a tick: decrement and flag expiry
        logic remove;     // close the gap at the selected entry
        logic from_head;  // the selected entry is the head (pop)
    } t_cell_cmd;

endpackage

>>> hw/rtl/dtf_in_if.sv
interface dtf_in_if;
    logic              valid;
    logic              ready;
    dtf_pkg::t_kind    kind;
    dtf_pkg::t_key     caller_key;
    dtf_pkg::t_ident   call_ident;
    dtf_pkg::t_ticks   timeout_ticks;

    modport source (output valid, kind, caller_key, call_ident, timeout_ticks, input ready);
    modport sink   (input valid, kind, caller_key, call_ident, timeout_ticks, output ready);
endinterface

>>> hw/rtl/dtf_out_if.sv
interface dtf_out_if;
    logic              valid;
    logic              ready;
    dtf_pkg::t_status  status;
    dtf_pkg::t_key     out_key;
    dtf_pkg::t_ident   out_call_ident;
    dtf_pkg::t_occ     occupancy;
    logic              last;

    modport source (output valid, status, out_key, out_call_ident, occupancy, last, input ready);
    modport sink   (input valid, status, out_key, out_call_ident, occupancy, last, output ready);
endinterface

>>> hw/rtl/dtf_cell.sv
module dtf_cell #(
    parameter int TIMEOUT_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dtf_pkg::t_cell_cmd      i_cmd,
    input  logic                    i_wr_en,
    input  dtf_pkg::t_key           i_key,
    input  dtf_pkg::t_ident         i_ident,
    input  logic [TIMEOUT_BITS-1:0] i_rem,
    input  logic                    i_nb_valid,
    input  dtf_pkg::t_key           i_nb_key,
    input  dtf_pkg::t_ident         i_nb_ident,
    input  logic [TIMEOUT_BITS-1:0] i_nb_rem,
    input  logic                    i_nb_exp,
    input  logic                    i_found,
    output logic                    o_found,
    output logic                    o_pick,
    output logic                    o_valid,
    output dtf_pkg::t_key           o_key,
    output dtf_pkg::t_ident         o_ident,
    output logic [TIMEOUT_BITS-1:0] o_rem,
    output logic                    o_exp,
    output logic                    o_match
);
    import dtf_pkg::*;

    logic                    r_valid;
    logic                    r_exp;
    logic                    r_match;
    t_key                    r_key;
    t_ident                  r_ident;
    logic [TIMEOUT_BITS-1:0] r_rem;
    logic                    shift;
    logic                    due;

    // Every cell at or behind the selected entry takes its younger neighbor.
    assign o_found = i_found | r_exp;
    assign o_pick  = r_exp & ~i_found;
    assign shift   = i_cmd.remove & o_found;
    assign due     = r_rem <= TIMEOUT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_exp   <= 1'b0;
            r_match <= 1'b0;
        end else if (shift) begin
            r_valid <= i_nb_valid;
            r_exp   <= i_nb_exp;
        end else if (i_wr_en) begin
            r_valid <= 1'b1;
            r_exp   <= 1'b0;
        end else if (i_cmd.scan) begin
            r_match <= r_valid && (r_key == i_key);
            r_exp   <= r_valid && i_cmd.is_tick && due;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_key   <= i_nb_key;
            r_ident <= i_nb_ident;
            r_rem   <= i_nb_rem;
        end else if (i_wr_en) begin
            r_key   <= i_key;
            r_ident <= i_ident;
            r_rem   <= i_rem;
        end else if (i_cmd.scan && i_cmd.is_tick && r_valid && !due) begin
            r_rem   <= r_rem - TIMEOUT_BITS'(1);
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_ident = r_ident;
    assign o_rem   = r_rem;
    assign o_exp   = r_exp;
    assign o_match = r_match;

endmodule

>>> hw/rtl/dedup_timeout_fifo_top.sv
// Channel   | Dir | Handshake     | Word
// ----------+-----+---------------+-----------------------------------------------
// i_req     | in  | valid / ready | kind, caller_key, call_ident, timeout_ticks
// o_rsp     | out | valid / ready | status, out_key, out_call_ident, occupancy, last
// i_cfg_*   | in  | write enable  | capacity_limit (5 bits)
//
// A push or a pop passes through accept, one parallel scan of the cell chain,
// and the result step. A tick scans the chain the same way and then reports one
// timed-out entry per result, or returns to idle with no result when none times out.
// The result register must be free before a result is written, so a stalled
// o_rsp holds the sequencer in its result step. Reset is synchronous and active low; it empties
// the queue and sets capacity_limit to 16. New words are taken only in idle.
module dedup_timeout_fifo_top #(
    parameter int DEPTH        = 16,
    parameter int TIMEOUT_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  dtf_pkg::t_cap i_cfg_wdata,
    dtf_in_if.sink        i_req,
    dtf_out_if.source     o_rsp
);
    import dtf_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > 5) ? CW : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // Registers.
    logic [1:0]              r_state, n_state;
    t_kind                   r_kind;
    t_key                    r_key;
    t_ident                  r_ident;
    logic [TIMEOUT_BITS-1:0] r_ticks;
    logic [CW-1:0]           r_count, n_count;
    t_cap                    r_cap;
    logic                    r_out_valid;
    t_status                 r_out_status, n_out_status;
    t_key                    r_out_key, n_out_key;
    t_ident                  r_out_ident, n_out_ident;
    t_occ                    r_out_occ, n_out_occ;
    logic                    r_out_last, n_out_last;

    // Chain wiring.
    t_cell_cmd               cmd;
    logic                    wr_en;
    logic [DEPTH:0]          found;
    logic [DEPTH-1:0]        valid_vec;
    logic [DEPTH-1:0]        exp_vec;
    logic [DEPTH-1:0]        pick_vec;
    logic [DEPTH-1:0]        match_vec;
    t_key                    c_key   [DEPTH];
    t_ident                  c_ident [DEPTH];
    logic [TIMEOUT_BITS-1:0] c_rem   [DEPTH];

    logic                    accept;
    logic                    out_free;
    logic                    load_out;
    logic                    any_match;
    logic                    any_exp;
    logic                    more_exp;
    logic                    full;
    logic [OW-1:0]           cnt_w, cnt_inc_w, cnt_dec_w, cap_eff;
    logic [31:0]             tick_ext;
    t_key                    sel_key;
    t_ident                  sel_ident;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign tick_ext    = 32'(i_req.timeout_ticks);

    assign any_match = |match_vec;
    assign any_exp   = |exp_vec;
    // Another timeout remains once the oldest flagged entry is reported.
    assign more_exp  = |(exp_vec & ~pick_vec);

    assign cnt_w     = OW'(r_count);
    assign cnt_inc_w = cnt_w + OW'(1);
    assign cnt_dec_w = cnt_w - OW'(1);
    // A capacity above the depth saturates at the depth.
    assign cap_eff   = (OW'(r_cap) > OW'(DEPTH)) ? OW'(DEPTH) : OW'(r_cap);
    assign full      = cnt_w >= cap_eff;

    // The oldest expired entry is picked by a one-hot from the chain.
    always_comb begin
        sel_key   = '0;
        sel_ident = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_key   = sel_key   | (c_key[i]   & {$bits(t_key){pick_vec[i]}});
            sel_ident = sel_ident | (c_ident[i] & {$bits(t_ident){pick_vec[i]}});
        end
    end

    // The sequencer drives the chain and fills the result register.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        cmd          = '0;
        wr_en        = 1'b0;
        load_out     = 1'b0;
        n_out_status = ST_ACCEPTED;
        n_out_key    = r_key;
        n_out_ident  = r_ident;
        n_out_occ    = cnt_w[4:0];
        n_out_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan    = 1'b1;
                cmd.is_tick = (r_kind == KIND_TICK);
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                unique case (r_kind)
                    KIND_PUSH: begin
                        if (out_free) begin
                            load_out = 1'b1;
                            n_state  = S_IDLE;
                            // The duplicate check wins over a full queue.
                            if (any_match) begin
                                n_out_status = ST_DUPLICATE;
                            end else if (full) begin
                                n_out_status = ST_OVERLOAD;
                            end else begin
                                wr_en        = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_out_status = ST_ACCEPTED;
                                n_out_occ    = cnt_inc_w[4:0];
                            end
                        end
                    end
                    KIND_POP: begin
                        if (out_free) begin
                            load_out = 1'b1;
                            n_state  = S_IDLE;
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                                n_out_key    = '0;
                                n_out_ident  = '0;
                                n_out_occ    = '0;
                            end else begin
                                cmd.remove    = 1'b1;
                                cmd.from_head = 1'b1;
                                n_count       = r_count - CW'(1);
                                n_out_status  = ST_POPPED;
                                n_out_key     = c_key[0];
                                n_out_ident   = c_ident[0];
                                n_out_occ     = cnt_dec_w[4:0];
                            end
                        end
                    end
                    KIND_TICK: begin
                        if (!any_exp) begin
                            n_state = S_IDLE;
                        end else if (out_free) begin
                            load_out     = 1'b1;
                            cmd.remove   = 1'b1;
                            n_count      = r_count - CW'(1);
                            n_out_status = ST_TIMEOUT;
                            n_out_key    = sel_key;
                            n_out_ident  = sel_ident;
                            n_out_occ    = cnt_dec_w[4:0];
                            n_out_last   = !more_exp;
                            if (!more_exp) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_req.kind;
            r_key   <= i_req.caller_key;
            r_ident <= i_req.call_ident;
            r_ticks <= tick_ext[TIMEOUT_BITS-1:0];
        end
        if (load_out) begin
            r_out_status <= n_out_status;
            r_out_key    <= n_out_key;
            r_out_ident  <= n_out_ident;
            r_out_occ    <= n_out_occ;
            r_out_last   <= n_out_last;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.out_key        = r_out_key;
    assign o_rsp.out_call_ident = r_out_ident;
    assign o_rsp.occupancy      = r_out_occ;
    assign o_rsp.last           = r_out_last;

    // Cell 0 is the head. A pop marks every cell as found so the whole row moves.
    assign found[0] = cmd.from_head;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                    nb_valid;
        t_key                    nb_key;
        t_ident                  nb_ident;
        logic [TIMEOUT_BITS-1:0] nb_rem;
        logic                    nb_exp;

        if (g == DEPTH - 1) begin : g_tail
            assign nb_valid = 1'b0;
            assign nb_key   = '0;
            assign nb_ident = '0;
            assign nb_rem   = '0;
            assign nb_exp   = 1'b0;
        end else begin : g_body
            assign nb_valid = valid_vec[g+1];
            assign nb_key   = c_key[g+1];
            assign nb_ident = c_ident[g+1];
            assign nb_rem   = c_rem[g+1];
            assign nb_exp   = exp_vec[g+1];
        end

        dtf_cell #(
            .TIMEOUT_BITS (TIMEOUT_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_wr_en    (wr_en && (r_count == CW'(g))),
            .i_key      (r_key),
            .i_ident    (r_ident),
            .i_rem      (r_ticks),
            .i_nb_valid (nb_valid),
            .i_nb_key   (nb_key),
            .i_nb_ident (nb_ident),
            .i_nb_rem   (nb_rem),
            .i_nb_exp   (nb_exp),
            .i_found    (found[g]),
            .o_found    (found[g+1]),
            .o_pick     (pick_vec[g]),
            .o_valid    (valid_vec[g]),
            .o_key      (c_key[g]),
            .o_ident    (c_ident[g]),
            .o_rem      (c_rem[g]),
            .o_exp      (exp_vec[g]),
            .o_match    (match_vec[g])
        );
    end

    // The queue never grows beyond the row of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_w <= OW'(DEPTH))
        else $error("entry count exceeds depth");

    // Occupied cells always form a packed run starting at the head.
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((valid_vec + DEPTH'(1)) & valid_vec) == '0))
        else $error("occupied cells are not packed at the head");

    // The count tracks the occupied cells.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_count))
        else $error("entry count disagrees with occupied cells");

    // Expiry flags only ever sit on occupied cells.
    a_exp_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exp_vec & ~valid_vec) == '0)
        else $error("expiry flag on an empty cell");

    // A final timeout report returns the sequencer to idle.
    a_tick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && n_out_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after the final result");

endmodule
